[rtl/bzh_pkg.sv]
// Shared types, constants and helpers for the cubic Bezier hit test block.
package bzh_pkg;

    localparam int COORD_BITS  = 16;
    localparam int T_FRAC_BITS = 24;
    localparam int TOL_BITS    = 10;
    localparam int PT_BITS     = 32;
    localparam int NUM_REGS    = 5;
    localparam int ADDR_BITS   = 5;
    localparam int IDX_BITS    = 3;

    // Q0.T_FRAC_BITS values that may reach one need one integer bit.
    localparam int T_W        = T_FRAC_BITS + 1;
    // Bernstein weights carry a factor of three.
    localparam int W_BITS     = T_W + 2;
    // Radicand of a polygon edge: sum of two squared 16-bit magnitudes.
    localparam int RAD_BITS   = 2 * COORD_BITS + 2;
    localparam int ROOT_ITERS = RAD_BITS / 2;
    localparam int LEN_BITS   = COORD_BITS + 3;
    localparam int ITER_BITS  = $clog2(T_W);
    localparam int ACC_BITS   = COORD_BITS + T_FRAC_BITS + 6;
    localparam int PROD_BITS  = W_BITS + 1 + COORD_BITS;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);

    localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    localparam logic [IDX_BITS-1:0] REG_START  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_FIRST  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_SECOND = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_END    = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_TOL    = 3'd4;

    localparam logic [TOL_BITS-1:0] TOL_RESET = 10'd4;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_CURVE = 2'd2;

    typedef struct packed {
        logic [3:0][PT_BITS-1:0] pt;
        logic [TOL_BITS-1:0]     tol;
    } bzh_cfg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] qx;
        logic signed [COORD_BITS-1:0] qy;
        logic                         pre_hit;
        logic [T_W-1:0]               step;
    } bzh_item_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_POINT,
        F_SQUARE,
        F_ROOT,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        W_IDLE,
        W_T2,
        W_U2,
        W_C0,
        W_C1,
        W_C2,
        W_C3,
        W_ACC,
        W_CHECK,
        W_DONE
    } walk_state_t;

    function automatic logic signed [COORD_BITS-1:0] pt_x(input logic [PT_BITS-1:0] p);
        pt_x = $signed(p[COORD_BITS-1:0]);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] pt_y(input logic [PT_BITS-1:0] p);
        pt_y = $signed(p[2*COORD_BITS-1:COORD_BITS]);
    endfunction

endpackage

[rtl/bzh_front.sv]
// Front end: accepts a query, tests the control points and derives the sample step.
module bzh_front
    import bzh_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bzh_cfg_t                     cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_query_x,
    input  logic signed [COORD_BITS-1:0] s_query_y,
    output logic                         push_valid,
    input  logic                         push_ready,
    output bzh_item_t                    push_data
);

    front_state_t                 state_reg, state_next;
    logic signed [COORD_BITS-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [1:0]                   idx_reg, idx_next;
    logic [ITER_BITS-1:0]         iter_reg, iter_next;
    logic                         pre_hit_reg, pre_hit_next;
    logic [RAD_BITS-1:0]          rad_reg, rad_next, root_reg, root_next, bit_reg, bit_next;
    logic [LEN_BITS-1:0]          len_reg, len_next;
    logic [LEN_BITS:0]            rem_reg, rem_next;
    logic [T_W-1:0]               quo_reg, quo_next, step_reg, step_next;

    logic signed [COORD_BITS-1:0] cur_x, cur_y, nxt_x, nxt_y;
    logic signed [COORD_BITS:0]   pdx, pdy, edx, edy;
    logic [COORD_BITS:0]          pax, pay, eax, eay;
    logic [2*TOL_BITS:0]          psum;
    logic [2*TOL_BITS-1:0]        tol_sq;
    logic                         near;
    logic [2*COORD_BITS:0]        esum;
    logic [RAD_BITS-1:0]          trial, root_step;
    logic                         root_ge;
    logic [LEN_BITS:0]            rem_shift;
    logic                         div_ge;
    logic [T_W-1:0]               quo_step;

    // Point idx_reg and the point after it, unpacked from the register file.
    assign cur_x = pt_x(cfg.pt[idx_reg]);
    assign cur_y = pt_y(cfg.pt[idx_reg]);
    assign nxt_x = pt_x(cfg.pt[idx_reg + 2'd1]);
    assign nxt_y = pt_y(cfg.pt[idx_reg + 2'd1]);

    // Circle test against the point selected by idx_reg.
    always_comb begin
        pdx    = {qx_reg[COORD_BITS-1], qx_reg} - {cur_x[COORD_BITS-1], cur_x};
        pdy    = {qy_reg[COORD_BITS-1], qy_reg} - {cur_y[COORD_BITS-1], cur_y};
        pax    = pdx[COORD_BITS] ? $unsigned(-pdx) : $unsigned(pdx);
        pay    = pdy[COORD_BITS] ? $unsigned(-pdy) : $unsigned(pdy);
        psum   = (2*TOL_BITS+1)'(pax[TOL_BITS-1:0] * pax[TOL_BITS-1:0])
               + (2*TOL_BITS+1)'(pay[TOL_BITS-1:0] * pay[TOL_BITS-1:0]);
        tol_sq = cfg.tol * cfg.tol;
        near   = (pax <= (COORD_BITS+1)'(cfg.tol)) && (pay <= (COORD_BITS+1)'(cfg.tol))
               && (psum <= (2*TOL_BITS+1)'(tol_sq));
    end

    // Squared length of polygon edge idx_reg, then one root bit and one quotient bit.
    always_comb begin
        edx  = {cur_x[COORD_BITS-1], cur_x} - {nxt_x[COORD_BITS-1], nxt_x};
        edy  = {cur_y[COORD_BITS-1], cur_y} - {nxt_y[COORD_BITS-1], nxt_y};
        eax  = edx[COORD_BITS] ? $unsigned(-edx) : $unsigned(edx);
        eay  = edy[COORD_BITS] ? $unsigned(-edy) : $unsigned(edy);
        esum = (2*COORD_BITS+1)'(eax[COORD_BITS-1:0] * eax[COORD_BITS-1:0])
             + (2*COORD_BITS+1)'(eay[COORD_BITS-1:0] * eay[COORD_BITS-1:0]);

        trial     = root_reg + bit_reg;
        root_ge   = rad_reg >= trial;
        root_step = root_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);

        rem_shift = {rem_reg[LEN_BITS-1:0], (iter_reg == ITER_BITS'(T_FRAC_BITS))};
        div_ge    = rem_shift >= {1'b0, len_reg};
        quo_step  = {quo_reg[T_W-2:0], div_ge};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:   if (s_valid) state_next = F_POINT;
            F_POINT: begin
                if (near) state_next = F_PUSH;
                else if (idx_reg == 2'd3) state_next = F_SQUARE;
            end
            F_SQUARE: state_next = F_ROOT;
            F_ROOT: begin
                if (iter_reg == '0) state_next = (idx_reg == 2'd2) ? F_DIV : F_SQUARE;
            end
            F_DIV:    if (iter_reg == '0) state_next = F_PUSH;
            F_PUSH:   if (push_ready) state_next = F_IDLE;
            default:  state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == F_IDLE);
        push_valid = (state_reg == F_PUSH);
        push_data  = '{qx: qx_reg, qy: qy_reg, pre_hit: pre_hit_reg, step: step_reg};
    end

    always_comb begin
        qx_next      = qx_reg;
        qy_next      = qy_reg;
        idx_next     = idx_reg;
        iter_next    = iter_reg;
        pre_hit_next = pre_hit_reg;
        rad_next     = rad_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        len_next     = len_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    qx_next      = s_query_x;
                    qy_next      = s_query_y;
                    idx_next     = 2'd0;
                    pre_hit_next = 1'b0;
                end
            end
            F_POINT: begin
                if (near) begin
                    pre_hit_next = 1'b1;
                end else if (idx_reg == 2'd3) begin
                    idx_next = 2'd0;
                    len_next = '0;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            F_SQUARE: begin
                rad_next  = RAD_BITS'(esum);
                root_next = '0;
                bit_next  = RAD_BITS'(1) << (RAD_BITS - 2);
                iter_next = ITER_BITS'(ROOT_ITERS - 1);
            end
            F_ROOT: begin
                if (root_ge) rad_next = rad_reg - trial;
                root_next = root_step;
                bit_next  = bit_reg >> 2;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0) begin
                    len_next = len_reg + LEN_BITS'(root_step);
                    idx_next = idx_reg + 2'd1;
                    rem_next = '0;
                    quo_next = '0;
                    iter_next = ITER_BITS'(T_FRAC_BITS);
                end
            end
            F_DIV: begin
                rem_next  = div_ge ? (rem_shift - {1'b0, len_reg}) : rem_shift;
                quo_next  = quo_step;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0) begin
                    if (len_reg == '0) step_next = T_ONE;
                    else if (quo_step == '0) step_next = T_W'(1);
                    else step_next = quo_step;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        idx_reg     <= idx_next;
        iter_reg    <= iter_next;
        pre_hit_reg <= pre_hit_next;
        rad_reg     <= rad_next;
        root_reg    <= root_next;
        bit_reg     <= bit_next;
        len_reg     <= len_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
    end

endmodule

[rtl/bzh_fifo.sv]
// Two-entry queue that decouples the front end from the curve walker.
module bzh_fifo
    import bzh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  bzh_item_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output bzh_item_t pop_data
);

    bzh_item_t             mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_BITS:0]     count_reg, count_next;
    logic                  do_push, do_pop;

    always_comb begin
        push_ready = (count_reg != (PTR_BITS+1)'(FIFO_DEPTH));
        pop_valid  = (count_reg != '0);
        pop_data   = mem[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop_valid && pop_ready;
        count_next = count_reg + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/bzh_walk.sv]
// Back end: walks the curve samples and holds the result register.
module bzh_walk
    import bzh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  bzh_cfg_t  cfg,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  bzh_item_t pop_data,
    output logic      m_valid,
    input  logic      m_ready,
    output logic      m_hit,
    output logic [1:0] m_hit_kind
);

    walk_state_t                  state_reg, state_next;
    logic signed [COORD_BITS-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [T_W-1:0]               step_reg, step_next, t_reg, t_next;
    logic [T_W-1:0]               t2_reg, t2_next, u2_reg, u2_next;
    logic [W_BITS-1:0]            c_reg [4];
    logic [W_BITS-1:0]            c_next [4];
    logic [1:0]                   k_reg, k_next;
    logic signed [ACC_BITS-1:0]   xs_reg, xs_next, ys_reg, ys_next;
    logic [1:0]                   kind_reg, kind_next;
    logic                         m_valid_reg, m_hit_reg;
    logic [1:0]                   m_kind_reg;

    logic [T_W-1:0]               u, op_a, op_b, wq;
    logic [2*T_W-1:0]             wprod;
    logic [W_BITS-1:0]            wq_ext, wq3;
    logic signed [PROD_BITS-1:0]  prod_x, prod_y;
    logic signed [ACC_BITS-1:0]   qxs, qys, tl, ntl, dx, dy;
    logic                         box_hit;
    logic [T_W-1:0]               t_sum;
    logic                         out_load;

    // One shared weight multiplier, operands picked by the sequencer state.
    always_comb begin
        u = T_ONE - t_reg;
        case (state_reg)
            W_T2:    begin op_a = t_reg;  op_b = t_reg; end
            W_U2:    begin op_a = u;      op_b = u;     end
            W_C0:    begin op_a = u2_reg; op_b = u;     end
            W_C1:    begin op_a = t_reg;  op_b = u2_reg; end
            W_C2:    begin op_a = t2_reg; op_b = u;     end
            default: begin op_a = t2_reg; op_b = t_reg; end
        endcase
        wprod  = op_a * op_b;
        wq     = wprod[T_FRAC_BITS +: T_W];
        wq_ext = W_BITS'(wq);
        wq3    = (wq_ext << 1) + wq_ext;

        prod_x = $signed({1'b0, c_reg[k_reg]}) * pt_x(cfg.pt[k_reg]);
        prod_y = $signed({1'b0, c_reg[k_reg]}) * pt_y(cfg.pt[k_reg]);

        qxs = $signed({{(ACC_BITS-COORD_BITS-T_FRAC_BITS){qx_reg[COORD_BITS-1]}},
                       qx_reg, {T_FRAC_BITS{1'b0}}});
        qys = $signed({{(ACC_BITS-COORD_BITS-T_FRAC_BITS){qy_reg[COORD_BITS-1]}},
                       qy_reg, {T_FRAC_BITS{1'b0}}});
        tl  = $signed({{(ACC_BITS-TOL_BITS-T_FRAC_BITS){1'b0}}, cfg.tol,
                       {T_FRAC_BITS{1'b0}}});
        ntl = -tl;
        dx  = qxs - xs_reg;
        dy  = qys - ys_reg;
        box_hit = (dx >= ntl) && (dx <= tl) && (dy >= ntl) && (dy <= tl);
        t_sum   = t_reg + step_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            W_IDLE: begin
                if (pop_valid) state_next = pop_data.pre_hit ? W_DONE : W_T2;
            end
            W_T2:    state_next = W_U2;
            W_U2:    state_next = W_C0;
            W_C0:    state_next = W_C1;
            W_C1:    state_next = W_C2;
            W_C2:    state_next = W_C3;
            W_C3:    state_next = W_ACC;
            W_ACC:   if (k_reg == 2'd3) state_next = W_CHECK;
            W_CHECK: begin
                if (box_hit || t_sum[T_FRAC_BITS]) state_next = W_DONE;
                else state_next = W_T2;
            end
            W_DONE:  if (!m_valid_reg || m_ready) state_next = W_IDLE;
            default: state_next = W_IDLE;
        endcase
    end

    always_comb begin
        pop_ready  = (state_reg == W_IDLE);
        out_load   = (state_reg == W_DONE) && (!m_valid_reg || m_ready);
        m_valid    = m_valid_reg;
        m_hit      = m_hit_reg;
        m_hit_kind = m_kind_reg;
    end

    always_comb begin
        qx_next   = qx_reg;
        qy_next   = qy_reg;
        step_next = step_reg;
        t_next    = t_reg;
        t2_next   = t2_reg;
        u2_next   = u2_reg;
        c_next    = c_reg;
        k_next    = k_reg;
        xs_next   = xs_reg;
        ys_next   = ys_reg;
        kind_next = kind_reg;
        case (state_reg)
            W_IDLE: begin
                if (pop_valid) begin
                    qx_next   = pop_data.qx;
                    qy_next   = pop_data.qy;
                    step_next = pop_data.step;
                    t_next    = '0;
                    kind_next = pop_data.pre_hit ? KIND_POINT : KIND_NONE;
                end
            end
            W_T2: t2_next = wq;
            W_U2: u2_next = wq;
            W_C0: c_next[0] = wq_ext;
            W_C1: c_next[1] = wq3;
            W_C2: c_next[2] = wq3;
            W_C3: begin
                c_next[3] = wq_ext;
                k_next    = 2'd0;
                xs_next   = '0;
                ys_next   = '0;
            end
            W_ACC: begin
                xs_next = xs_reg + ACC_BITS'(prod_x);
                ys_next = ys_reg + ACC_BITS'(prod_y);
                k_next  = k_reg + 2'd1;
            end
            W_CHECK: begin
                if (box_hit) kind_next = KIND_CURVE;
                else t_next = t_sum;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= W_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        step_reg <= step_next;
        t_reg    <= t_next;
        t2_reg   <= t2_next;
        u2_reg   <= u2_next;
        c_reg    <= c_next;
        k_reg    <= k_next;
        xs_reg   <= xs_next;
        ys_reg   <= ys_next;
        kind_reg <= kind_next;
        if (out_load) begin
            m_hit_reg  <= (kind_reg != KIND_NONE);
            m_kind_reg <= kind_reg;
        end
    end

endmodule

[rtl/bezier_curve_hit_test.sv]
// Top level of the cubic Bezier hit test: register file, front end, queue and curve walker.
//
// A query point enters on the s_ channel (s_valid/s_ready, one transaction per point)
// and one result leaves on the m_ channel for each query: m_hit and m_hit_kind, where
// the kind says none, near a configured point, or near a curve sample.
// The four curve points and the tolerance are written through the APB port only while the
// block is idle; the user must ensure this, the block does not enforce it. pready is
// always high and reads return the stored values. The front end runs the four circle
// tests one point at a time; on a miss it takes the square root of each of the three
// polygon edges (one root bit per cycle) and divides for the sample step (one quotient
// bit per cycle). The walker takes each sample through W_T2, W_U2, W_C0 to W_C3, W_ACC
// per point and W_CHECK on its shared weight multiplier and coordinate accumulators;
// a curve of polygon length L takes about L samples (a little more for long curves,
// as the step is rounded down, and one sample when L is zero), fewer when a sample hits
// early. A two-entry queue sits between the two halves, so the front end can work on the
// next query while the walker is busy. Results sit in an output register; when the
// receiver stalls, the walker holds its finished result, the queue fills and the front
// end holds its item with s_ready low. Reset (aresetn, synchronous, active low) empties
// the queue, idles both halves, clears the points to zero and sets the tolerance to 4.
module bezier_curve_hit_test
    import bzh_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_query_x,
    input  logic signed [COORD_BITS-1:0] s_query_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic [1:0]                   m_hit_kind
);

    logic [PT_BITS-1:0]  start_reg, first_reg, second_reg, end_reg;
    logic [TOL_BITS-1:0] tol_reg;
    logic [IDX_BITS-1:0] reg_idx;
    logic                cfg_write;
    bzh_cfg_t            cfg;

    logic      push_valid, push_ready, pop_valid, pop_ready;
    bzh_item_t push_data, pop_data;

    // Registers sit on word boundaries; the two low address bits are ignored.
    assign reg_idx   = paddr[ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            end_reg    <= '0;
            tol_reg    <= TOL_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_START:  start_reg  <= pwdata;
                REG_FIRST:  first_reg  <= pwdata;
                REG_SECOND: second_reg <= pwdata;
                REG_END:    end_reg    <= pwdata;
                REG_TOL:    tol_reg    <= pwdata[TOL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_START:  prdata = start_reg;
            REG_FIRST:  prdata = first_reg;
            REG_SECOND: prdata = second_reg;
            REG_END:    prdata = end_reg;
            REG_TOL:    prdata = 32'(tol_reg);
            default:    prdata = '0;
        endcase
    end

    // Point order matters: pt[0] is the curve's start point and pt[3] its end point.
    assign cfg.pt  = {end_reg, second_reg, first_reg, start_reg};
    assign cfg.tol = tol_reg;

    bzh_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_query_x  (s_query_x),
        .s_query_y  (s_query_y),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bzh_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bzh_walk u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hit      (m_hit),
        .m_hit_kind (m_hit_kind)
    );

endmodule

[verif/tb_bezier_curve_hit_test.sv]
// Testbench for bezier_curve_hit_test: directed and random queries checked against a predictor.
`timescale 1ns / 1ps

module tb_bezier_curve_hit_test;
    import bzh_pkg::*;

    // Clock, reset and the configuration port.
    logic                         aclk;
    logic                         aresetn;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [ADDR_BITS-1:0]         paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    // Query channel and result channel.
    logic                         s_valid;
    logic                         s_ready;
    logic signed [COORD_BITS-1:0] s_query_x;
    logic signed [COORD_BITS-1:0] s_query_y;
    logic                         m_valid;
    logic                         m_ready;
    logic                         m_hit;
    logic [1:0]                   m_hit_kind;

    typedef struct packed {
        logic       hit;
        logic [1:0] kind;
    } hit_result_t;

    // Expected results, oldest first.
    hit_result_t pending_hits[$];

    // Shadow copy of the configuration that the predictor works from.
    logic [PT_BITS-1:0]  curve_pts[4];
    logic [TOL_BITS-1:0] curve_tol;

    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned queries_sent;
    int unsigned results_seen;
    int unsigned point_hits;
    int unsigned curve_hits;
    int unsigned sender_gap_max;
    int unsigned result_stall_max;
    int          result_stall;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam longint      Q_ONE       = longint'(1) << T_FRAC_BITS;

    bezier_curve_hit_test dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_query_x  (s_query_x),
        .s_query_y  (s_query_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hit      (m_hit),
        .m_hit_kind (m_hit_kind)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Integer square root, floor, by the usual bit-pair method.
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = longint'(1) << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Truncating Q0.24 product; a factor of exactly one passes the other through.
    function automatic longint qmul(input longint a, input longint b);
        if (a == Q_ONE) return b;
        if (b == Q_ONE) return a;
        return (a * b) >>> T_FRAC_BITS;
    endfunction

    function automatic longint abs_l(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Works out hit and kind for one query against the shadow configuration.
    function automatic hit_result_t predict_hit(input logic signed [COORD_BITS-1:0] qx_in,
                                                input logic signed [COORD_BITS-1:0] qy_in);
        longint      px[4];
        longint      py[4];
        longint      qx;
        longint      qy;
        longint      tl;
        longint      ax;
        longint      ay;
        longint      poly_len;
        longint      step;
        longint      t;
        longint      u;
        longint      t2;
        longint      u2;
        longint      w[4];
        longint      xs;
        longint      ys;
        longint      d;
        hit_result_t r;
        qx = longint'(qx_in);
        qy = longint'(qy_in);
        tl = longint'(curve_tol);
        r.hit = 1'b0;
        r.kind = KIND_NONE;
        for (int i = 0; i < 4; i++) begin
            px[i] = longint'(pt_x(curve_pts[i]));
            py[i] = longint'(pt_y(curve_pts[i]));
        end
        // Circle test around each configured point, in register order.
        for (int i = 0; i < 4; i++) begin
            ax = abs_l(qx - px[i]);
            ay = abs_l(qy - py[i]);
            if (ax <= tl && ay <= tl && ax * ax + ay * ay <= tl * tl) begin
                r.hit = 1'b1;
                r.kind = KIND_POINT;
                return r;
            end
        end
        poly_len = 0;
        for (int i = 0; i < 3; i++) begin
            ax = abs_l(px[i] - px[i + 1]);
            ay = abs_l(py[i] - py[i + 1]);
            poly_len += longint'(floor_sqrt(ax * ax + ay * ay));
        end
        if (poly_len == 0) begin
            step = Q_ONE;
        end else begin
            step = Q_ONE / poly_len;
            if (step == 0) step = 1;
        end
        // Curve walk with a box test in Q.24, limits inclusive.
        t = 0;
        while (t < Q_ONE) begin
            u = Q_ONE - t;
            t2 = qmul(t, t);
            u2 = qmul(u, u);
            w[0] = qmul(u2, u);
            w[1] = 3 * qmul(t, u2);
            w[2] = 3 * qmul(t2, u);
            w[3] = qmul(t2, t);
            xs = 0;
            ys = 0;
            for (int k = 0; k < 4; k++) begin
                xs += w[k] * px[k];
                ys += w[k] * py[k];
            end
            d = (qx <<< T_FRAC_BITS) - xs;
            if (d >= -(tl <<< T_FRAC_BITS) && d <= (tl <<< T_FRAC_BITS)) begin
                d = (qy <<< T_FRAC_BITS) - ys;
                if (d >= -(tl <<< T_FRAC_BITS) && d <= (tl <<< T_FRAC_BITS)) begin
                    r.hit = 1'b1;
                    r.kind = KIND_CURVE;
                    return r;
                end
            end
            t += step;
        end
        return r;
    endfunction

    // One APB write: a setup phase, then an access phase; the shadow copy follows.
    task automatic apb_write(input logic [IDX_BITS-1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_BITS'(idx) << 2;
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_TOL) begin
            curve_tol = value[TOL_BITS-1:0];
        end else begin
            curve_pts[idx] = value;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [31:0] pack_pt(input int x, input int y);
        return {16'(y), 16'(x)};
    endfunction

    // Writes a whole curve. Only called with the block idle.
    task automatic load_curve(input int x0, input int y0, input int x1, input int y1,
                              input int x2, input int y2, input int x3, input int y3,
                              input int tol);
        apb_write(REG_START, pack_pt(x0, y0));
        apb_write(REG_FIRST, pack_pt(x1, y1));
        apb_write(REG_SECOND, pack_pt(x2, y2));
        apb_write(REG_END, pack_pt(x3, y3));
        apb_write(REG_TOL, 32'(tol));
    endtask

    // Sends one query transaction after a random gap. Valid stays high between
    // back-to-back transactions; the expectation is queued at acceptance.
    task automatic send_query(input int qx, input int qy);
        int unsigned gap;
        gap = $urandom_range(0, sender_gap_max);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_query_x = 16'(qx);
        s_query_y = 16'(qy);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_hits.push_back(predict_hit(s_query_x, s_query_y));
        queries_sent++;
        @(negedge aclk);
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic drain;
        s_valid = 1'b0;
        while (pending_hits.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // With everything at reset the curve collapses to the origin: zero polygon
    // length, so only the t = 0 sample is walked. The box corner at (3, 3) misses
    // the circle but lands in the box. Also covers the extremes of both fields.
    task automatic test_reset_defaults;
        sender_gap_max = 0;
        result_stall_max = 0;
        send_query(0, 0);
        send_query(4, 0);
        send_query(0, -4);
        send_query(3, 3);
        send_query(-3, 3);
        send_query(5, 0);
        send_query(4, 5);
        send_query(-32768, 32767);
        send_query(32767, -32768);
        send_query(-32768, -32768);
        send_query(32767, 32767);
        send_query(-1, -1);
        drain();
    endtask

    // Tolerance extremes on a short straight curve.
    task automatic test_tolerance_extremes;
        sender_gap_max = 4;
        result_stall_max = 4;
        load_curve(100, 100, 110, 100, 120, 100, 130, 100, 0);
        send_query(100, 100);
        send_query(130, 100);
        send_query(115, 100);
        send_query(115, 101);
        send_query(99, 100);
        drain();
        apb_write(REG_TOL, 32'd1023);
        send_query(1123, 100);
        send_query(130 + 1023, 100 + 1023);
        send_query(100 - 1024, 100);
        send_query(115, 100 - 1023);
        send_query(-32768, 32767);
        drain();
    endtask

    // Corners of the coordinate range: a polygon hundreds of thousands long.
    // Queries stay near the control points, so each hits a circle or the walk ends on its first sample.
    task automatic test_far_points;
        sender_gap_max = 2;
        result_stall_max = 2;
        load_curve(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 1023);
        send_query(-32768, -32768);
        send_query(-32768 + 1000, -32768 + 1000);
        send_query(-32768 + 1023, -32768 + 1023);
        send_query(32767, 32767);
        send_query(32767 - 700, -32768 + 700);
        drain();
    endtask

    // Random short curves anywhere in the plane, mostly with queries near the
    // control polygon so that all three outcomes come up often.
    task automatic test_random_curves(input int unsigned phases, input int unsigned per_phase);
        int bx;
        int by;
        int ox[4];
        int oy[4];
        int tol;
        int reach;
        int pick;
        for (int unsigned p = 0; p < phases; p++) begin
            // Every third phase runs with no idling on either side.
            sender_gap_max = (p % 3 == 2) ? 0 : 16;
            result_stall_max = (p % 3 == 2) ? 0 : 16;
            bx = int'($urandom_range(0, 60000)) - 30000;
            by = int'($urandom_range(0, 60000)) - 30000;
            for (int i = 0; i < 4; i++) begin
                ox[i] = bx + int'($urandom_range(0, 50)) - 25;
                oy[i] = by + int'($urandom_range(0, 50)) - 25;
            end
            case ($urandom_range(0, 7))
                0: tol = 0;
                1: tol = 1023;
                default: tol = $urandom_range(1, 12);
            endcase
            load_curve(ox[0], oy[0], ox[1], oy[1], ox[2], oy[2], ox[3], oy[3], tol);
            reach = (tol > 100 ? 100 : tol) + 8;
            for (int unsigned n = 0; n < per_phase; n++) begin
                if ($urandom_range(0, 9) < 7) begin
                    pick = $urandom_range(0, 3);
                    send_query(ox[pick] + int'($urandom_range(0, 2 * reach)) - reach,
                               oy[pick] + int'($urandom_range(0, 2 * reach)) - reach);
                end else begin
                    send_query(int'($urandom_range(0, 65535)) - 32768,
                               int'($urandom_range(0, 65535)) - 32768);
                end
            end
            drain();
        end
    endtask

    // Result checker: compares each accepted result with the oldest expectation
    // and draws the stall before the receiver takes the next one.
    always @(posedge aclk) begin
        hit_result_t exp_hit;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            result_stall = $urandom_range(0, result_stall_max);
            if (pending_hits.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: hit=%0d kind=%0d", m_hit, m_hit_kind);
            end else begin
                exp_hit = pending_hits.pop_front();
                if (m_hit !== exp_hit.hit || m_hit_kind !== exp_hit.kind) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d mismatch: expected hit=%0d kind=%0d, got hit=%0d kind=%0d",
                                 results_seen, exp_hit.hit, exp_hit.kind, m_hit, m_hit_kind);
                end else if (exp_hit.kind == KIND_POINT) begin
                    point_hits++;
                end else if (exp_hit.kind == KIND_CURVE) begin
                    curve_hits++;
                end
            end
        end
    end

    // Receiver: holds ready low for the drawn stall, then raises it.
    always @(negedge aclk) begin
        if (result_stall > 0) begin
            m_ready = 1'b0;
            result_stall--;
        end else begin
            m_ready = 1'b1;
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_hits.size());
            $display("tb_bezier_curve_hit_test: done, errors");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_query_x = '0;
        s_query_y = '0;
        m_ready = 1'b0;
        result_stall = 0;
        sender_gap_max = 0;
        result_stall_max = 0;
        cycle_count = 0;
        mismatch_count = 0;
        queries_sent = 0;
        results_seen = 0;
        point_hits = 0;
        curve_hits = 0;
        for (int i = 0; i < 4; i++) curve_pts[i] = '0;
        curve_tol = TOL_RESET;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_tolerance_extremes();
        test_far_points();
        test_random_curves(10, 26);

        s_valid = 1'b0;
        repeat (50) @(negedge aclk);
        $display("%0d queries, %0d results: %0d near a point, %0d near the curve, %0d cycles",
                 queries_sent, results_seen, point_hits, curve_hits, cycle_count);
        $display("curves covered: collapsed, straight, corner to corner, and 10 random ones");
        if (mismatch_count == 0 && pending_hits.size() == 0) begin
            $display("tb_bezier_curve_hit_test: done, clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count, pending_hits.size());
            $display("tb_bezier_curve_hit_test: done, errors");
        end
        $finish;
    end

endmodule

[bezier_curve_hit_test.f]
rtl/bzh_pkg.sv
rtl/bzh_front.sv
rtl/bzh_fifo.sv
rtl/bzh_walk.sv
rtl/bezier_curve_hit_test.sv
verif/tb_bezier_curve_hit_test.sv
